// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the printable string extractor.
// Each macro expands to a labelled concurrent assertion, or to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked on every rising edge while reset is released.
`define PSX_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Implication checked on every rising edge while reset is released.
`define PSX_ASSERT_IMP(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
`else
`define PSX_ASSERT(name, clk, rstn, prop)
`define PSX_ASSERT_IMP(name, clk, rstn, pre, post)
`endif

`endif

// ===== design/psx_pkg.sv =====
// Package of the printable string extractor: field widths and fixed codes.
// Used by printable_string_extractor_core; depends on nothing.
`default_nettype none

package psx_pkg;

    localparam int BYTE_W = 8;
    localparam int RUN_W  = 6;

    // Default depth of the hold memory, i.e. the largest usable minimum length.
    localparam int DEFAULT_MAX_MIN_LEN = 32;

    localparam logic [BYTE_W-1:0] PRINT_LO = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HI = 8'd126;

    // Run counter code for a run that has been reported and now passes through.
    localparam logic [RUN_W-1:0] RUN_PASSING   = 6'd63;
    localparam logic [RUN_W-1:0] MIN_LEN_RESET = 6'd4;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [RUN_W-1:0]  run_t;

endpackage

`default_nettype wire

// ===== design/printable_string_extractor_core.sv =====
// Printable string extractor: finds runs of printable ASCII bytes in a byte stream.
// Depends on psx_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one raw byte and an end-of-buffer flag.
//   Output channel (m_valid/m_ready) carries string bytes, end markers (m_is_end = 1,
//   m_out_byte = 0) and a flag on the last result caused by each input transaction.
//   cfg_wr_en/cfg_wr_data write the minimum run length; write it only while idle.
// Timing:
//   A byte that produces one result shows it on m_valid in the cycle after acceptance.
//   A pass-through byte that ends the buffer keeps the block busy until its end marker
//   is loaded; a lone end marker leaves the controller idle. Held bytes come from the
//   hold memory, which has a registered read, so a release first reads the oldest held
//   byte into rd_data_reg and then hands on one transaction per cycle while the output
//   register is free. A release of k held bytes gives k + 1 results (plus a closing end marker).
// Stalls and reset:
//   s_ready requires the controller to be idle and the output register to be free
//   or draining in the same cycle, so a stalled receiver holds the input back.
//   Synchronous active-low reset closes any open run and empties the output register;
//   the hold memory needs no clearing as every entry is written before it is read.
`default_nettype none

module printable_string_extractor_core #(
    parameter int MAX_MIN_LEN = psx_pkg::DEFAULT_MAX_MIN_LEN
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [psx_pkg::BYTE_W-1:0]    s_data_byte,
    input  wire                           s_end_of_buffer,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [psx_pkg::BYTE_W-1:0]    m_out_byte,
    output logic                          m_is_end,
    output logic                          m_last_of_run,
    input  wire                           cfg_wr_en,
    input  wire  [psx_pkg::RUN_W-1:0]     cfg_wr_data
);

`include "assert_macros.svh"

    localparam int AW = (MAX_MIN_LEN > 1) ? $clog2(MAX_MIN_LEN) : 1;
    localparam psx_pkg::run_t MAX_LEN = psx_pkg::RUN_W'(MAX_MIN_LEN);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_BYTE  = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    logic [1:0]      state_reg, state_next;
    psx_pkg::run_t   run_reg, run_next;
    psx_pkg::run_t   idx_reg, idx_next;
    psx_pkg::run_t   min_len_reg;
    psx_pkg::byte_t  byte_reg, byte_next;
    logic            eob_reg, eob_next;

    psx_pkg::byte_t  hold_mem [MAX_MIN_LEN];
    psx_pkg::byte_t  rd_data_reg;
    logic            mem_we, mem_re;
    logic [AW-1:0]   rd_addr;

    logic            m_valid_reg;
    psx_pkg::byte_t  out_byte_reg;
    logic            is_end_reg, last_reg;

    logic            out_free, load;
    psx_pkg::byte_t  ld_byte;
    logic            ld_end, ld_last;
    logic            printable, release_now;
    psx_pkg::run_t   min_eff, idx_inc, run_dec;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign printable = (s_data_byte >= psx_pkg::PRINT_LO) && (s_data_byte <= psx_pkg::PRINT_HI);
    assign idx_inc   = idx_reg + 6'd1;
    assign run_dec   = run_reg - 6'd1;

    // Effective minimum: zero behaves as one, large values clamp to the memory depth.
    always_comb begin
        priority if (min_len_reg == '0) begin
            min_eff = 6'd1;
        end else if (min_len_reg > MAX_LEN) begin
            min_eff = MAX_LEN;
        end else begin
            min_eff = min_len_reg;
        end
    end

    assign release_now = ({1'b0, run_reg} + 7'd1) >= {1'b0, min_eff};

    always_comb begin
        state_next = state_reg;
        run_next   = run_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        eob_next   = eob_reg;
        load       = 1'b0;
        ld_byte    = '0;
        ld_end     = 1'b0;
        ld_last    = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        rd_addr    = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (printable) begin
                        if (run_reg == psx_pkg::RUN_PASSING || (release_now && run_reg == '0)) begin
                            load    = 1'b1;
                            ld_byte = s_data_byte;
                            ld_last = !s_end_of_buffer;
                            if (s_end_of_buffer) begin
                                state_next = ST_END;
                                run_next   = '0;
                            end else begin
                                run_next = psx_pkg::RUN_PASSING;
                            end
                        end else if (release_now) begin
                            // Held bytes go out first; start reading the oldest one now.
                            byte_next  = s_data_byte;
                            eob_next   = s_end_of_buffer;
                            idx_next   = '0;
                            mem_re     = 1'b1;
                            rd_addr    = '0;
                            state_next = ST_FLUSH;
                        end else begin
                            mem_we   = 1'b1;
                            run_next = s_end_of_buffer ? '0 : run_reg + 6'd1;
                        end
                    end else begin
                        if (run_reg == psx_pkg::RUN_PASSING) begin
                            load    = 1'b1;
                            ld_end  = 1'b1;
                            ld_last = 1'b1;
                        end
                        run_next = '0;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = rd_data_reg;
                    if (idx_reg == run_dec) begin
                        state_next = ST_BYTE;
                    end else begin
                        idx_next = idx_inc;
                        mem_re   = 1'b1;
                        rd_addr  = idx_inc[AW-1:0];
                    end
                end
            end
            ST_BYTE: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_byte = byte_reg;
                    ld_last = !eob_reg;
                    if (eob_reg) begin
                        state_next = ST_END;
                        run_next   = '0;
                    end else begin
                        state_next = ST_IDLE;
                        run_next   = psx_pkg::RUN_PASSING;
                    end
                end
            end
            ST_END: begin
                if (out_free) begin
                    load       = 1'b1;
                    ld_end     = 1'b1;
                    ld_last    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Hold memory: written while a run is short, read back in order on release.
    // Only one transaction is in flight, so a write and a read never meet on one entry.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hold_mem[run_reg[AW-1:0]] <= s_data_byte;
        end
        if (mem_re) begin
            rd_data_reg <= hold_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            run_reg     <= '0;
            idx_reg     <= '0;
            min_len_reg <= psx_pkg::MIN_LEN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            run_reg   <= run_next;
            idx_reg   <= idx_next;
            if (cfg_wr_en) begin
                min_len_reg <= cfg_wr_data;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        eob_reg  <= eob_next;
        if (load) begin
            out_byte_reg <= ld_byte;
            is_end_reg   <= ld_end;
            last_reg     <= ld_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_is_end      = is_end_reg;
    assign m_last_of_run = last_reg;

    `PSX_ASSERT(a_run_range, aclk, aresetn,
        run_reg < MAX_LEN || run_reg == psx_pkg::RUN_PASSING)
    `PSX_ASSERT_IMP(a_flush_has_bytes, aclk, aresetn, state_reg == ST_FLUSH,
        run_reg != '0 && run_reg != psx_pkg::RUN_PASSING && idx_reg < run_reg)
    `PSX_ASSERT_IMP(a_end_marker_form, aclk, aresetn, m_valid_reg && is_end_reg,
        last_reg && out_byte_reg == '0)
    `PSX_ASSERT_IMP(a_end_closes_run, aclk, aresetn, state_reg == ST_END, run_reg == '0)

endmodule

`default_nettype wire
